### hdl/ilir_pkg.sv
// Shared request codes, status codes and cell control types for the list unit.
package ilir_pkg;

    // Request type codes
    localparam logic [1:0] REQ_INSERT = 2'd0;
    localparam logic [1:0] REQ_REMOVE = 2'd1;
    localparam logic [1:0] REQ_PEEK   = 2'd2;

    // Status codes
    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_EMPTY = 2'd1;
    localparam logic [1:0] ST_RANGE = 2'd2;
    localparam logic [1:0] ST_FULL  = 2'd3;

    // What one cell does at the next clock edge
    typedef enum logic [1:0] {
        CELL_HOLD,
        CELL_LOAD,
        CELL_FROM_LEFT,
        CELL_FROM_RIGHT
    } cell_op_t;

    typedef struct packed {
        cell_op_t op;
        logic     rd_sel;
    } cell_ctrl_t;

endpackage

### hdl/ilir_cell.sv
// One storage cell of the list row: holds an entry and shifts with its neighbors.
module ilir_cell #(
    parameter int DATA_WIDTH = 8
) (
    input  logic                    clk,
    input  ilir_pkg::cell_ctrl_t    ctrl,
    input  logic [DATA_WIDTH-1:0]   load_data,
    input  logic [DATA_WIDTH-1:0]   left_data,
    input  logic [DATA_WIDTH-1:0]   right_data,
    output logic [DATA_WIDTH-1:0]   data,
    output logic [DATA_WIDTH-1:0]   tap
);
    import ilir_pkg::*;

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;

    // Select the next entry value
    always_comb
    begin
        case (ctrl.op)
            CELL_LOAD:       data_next = load_data;
            CELL_FROM_LEFT:  data_next = left_data;
            CELL_FROM_RIGHT: data_next = right_data;
            default:         data_next = data_reg;
        endcase
    end

    // Hold the entry; payload needs no reset
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data = data_reg;

    // Drive the read bus only when this cell is addressed
    assign tap = ctrl.rd_sel ? data_reg : '0;

endmodule

### hdl/indexed_list_insert_remove_unit.sv
// Ordered list of up to MAX_ENTRIES values kept in a shifting row of cells.
// A result strobes on done in the cycle after the request is accepted.
// Throughput: one request per cycle; every cell shifts in the same cycle, so busy stays low.
// Count and the result strobe clear on reset; cell contents are undefined until written.
// The receiver cannot stall: done is high for a single cycle per result; the payload holds until the next request.
module indexed_list_insert_remove_unit #(
    parameter int MAX_ENTRIES = 16,
    parameter int DATA_WIDTH  = 8,
    localparam int POS_W      = $clog2(MAX_ENTRIES + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            req_type,
    input  logic [POS_W-1:0]      list_position,
    input  logic [DATA_WIDTH-1:0] data_in,
    output logic                  done,
    output logic [1:0]            status,
    output logic [DATA_WIDTH-1:0] data_out,
    output logic [POS_W-1:0]      list_length
);
    import ilir_pkg::*;

    localparam logic [POS_W-1:0] MAX_LEN = POS_W'(MAX_ENTRIES);

    logic [POS_W-1:0]      count_reg;
    logic [POS_W-1:0]      count_next;
    logic                  done_reg;
    logic [1:0]            status_reg;
    logic [1:0]            status_next;
    logic [DATA_WIDTH-1:0] data_out_reg;
    logic [DATA_WIDTH-1:0] data_out_next;
    logic [POS_W-1:0]      list_length_reg;

    logic                  accept;
    logic                  ins_ok;
    logic                  rem_ok;
    logic                  rd_ok;
    logic [DATA_WIDTH-1:0] rd_data;

    cell_ctrl_t            ctrl [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0] cell_data [MAX_ENTRIES];
    logic [DATA_WIDTH-1:0] cell_tap [MAX_ENTRIES];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    // Decode the request against the current length
    always_comb
    begin
        ins_ok      = 1'b0;
        rem_ok      = 1'b0;
        rd_ok       = 1'b0;
        status_next = ST_RANGE;
        case (req_type)
            REQ_INSERT:
            begin
                if (list_position > count_reg)
                    status_next = ST_RANGE;
                else if (count_reg >= MAX_LEN)
                    status_next = ST_FULL;
                else
                begin
                    status_next = ST_OK;
                    ins_ok      = 1'b1;
                end
            end
            REQ_REMOVE, REQ_PEEK:
            begin
                if (count_reg == '0)
                    status_next = ST_EMPTY;
                else if (list_position >= count_reg)
                    status_next = ST_RANGE;
                else
                begin
                    status_next = ST_OK;
                    rd_ok       = 1'b1;
                    rem_ok      = (req_type == REQ_REMOVE);
                end
            end
            default:
                status_next = ST_RANGE;
        endcase
    end

    // Build the per-cell shift controls
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_ctrl
        localparam logic [POS_W-1:0] IDX = POS_W'(i);
        always_comb
        begin
            ctrl[i].rd_sel = (IDX == list_position);
            ctrl[i].op     = CELL_HOLD;
            if (accept && ins_ok)
            begin
                if (IDX == list_position)
                    ctrl[i].op = CELL_LOAD;
                else if (IDX > list_position && IDX <= count_reg)
                    ctrl[i].op = CELL_FROM_LEFT;
            end
            else if (accept && rem_ok)
            begin
                if (IDX >= list_position && i < MAX_ENTRIES - 1)
                    ctrl[i].op = CELL_FROM_RIGHT;
            end
        end
    end

    // Row of cells, each wired to its neighbors
    for (genvar i = 0; i < MAX_ENTRIES; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_d;
        logic [DATA_WIDTH-1:0] right_d;
        if (i == 0)
        begin : g_first
            assign left_d = data_in;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end
        if (i == MAX_ENTRIES - 1)
        begin : g_last
            assign right_d = cell_data[i];
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ilir_cell #(
            .DATA_WIDTH(DATA_WIDTH)
        ) u_cell (
            .clk       (clk),
            .ctrl      (ctrl[i]),
            .load_data (data_in),
            .left_data (left_d),
            .right_data(right_d),
            .data      (cell_data[i]),
            .tap       (cell_tap[i])
        );
    end

    // Merge the cell read taps
    always_comb
    begin
        rd_data = '0;
        for (int i = 0; i < MAX_ENTRIES; i++)
            rd_data = rd_data | cell_tap[i];
    end

    // Advance the length
    always_comb
    begin
        count_next = count_reg;
        if (accept && ins_ok)
            count_next = count_reg + 1'b1;
        else if (accept && rem_ok)
            count_next = count_reg - 1'b1;
    end

    assign data_out_next = rd_ok ? rd_data : '0;

    // Hold length and the result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    // Register the result transaction payload
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            status_reg      <= status_next;
            data_out_reg    <= data_out_next;
            list_length_reg <= count_next;
        end
    end

    assign done        = done_reg;
    assign status      = status_reg;
    assign data_out    = data_out_reg;
    assign list_length = list_length_reg;

    // Length never exceeds the pool
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= MAX_LEN)
        else $error("list length exceeds capacity");

    // Every accepted request gives one result next cycle
    a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("accepted request gave no result");

    // Full status only on a full list
    a_full_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_FULL |-> list_length == MAX_LEN)
        else $error("full status with list not full");

    // Empty status only on an empty list
    a_empty_len: assert property (@(posedge clk) disable iff (!rst_n)
        done && status == ST_EMPTY |-> list_length == '0)
        else $error("empty status with list not empty");

    // A successful insert grows the list by one
    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        accept && ins_ok |=> list_length == $past(count_reg) + 1'b1)
        else $error("insert did not grow the list");

endmodule
